// ===== rtl/dcsf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the dual-channel selectable FIR: default sizes, item kinds,
// filter and register codes, sequencer states and the MAC control bundle.
// No dependencies.
package dcsf_pkg;

  localparam int DEF_MAX_TAPS    = 512;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_LOAD_HP = 2'd1;
  localparam logic [1:0] KIND_LOAD_LP = 2'd2;

  localparam logic [1:0] FILT_HIGH = 2'd1;
  localparam logic [1:0] FILT_LOW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HP_TAPS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LP_TAPS  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       step;
    logic [1:0] en;
  } mac_ctrl_t;

endpackage

// ===== rtl/dcsf_mac.sv =====
`timescale 1ns / 1ps
// Two-lane multiply-accumulate unit with round-half-up and saturation.
// Depends on dcsf_pkg (mac_ctrl_t).
module dcsf_mac
  import dcsf_pkg::*;
#(
  parameter int MAX_TAPS    = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0] hist_one,
  input  logic signed [SAMPLE_BITS-1:0] hist_two,
  input  logic signed [SAMPLE_BITS-1:0] coef_one,
  input  logic signed [SAMPLE_BITS-1:0] coef_two,
  output logic signed [SAMPLE_BITS-1:0] res_one,
  output logic signed [SAMPLE_BITS-1:0] res_two
);

  localparam int FRAC  = SAMPLE_BITS - 1;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
  localparam int RND_W  = ACC_W + 1;
  localparam logic signed [RND_W-1:0] HALF  = RND_W'(1) <<< (FRAC - 1);
  localparam logic signed [RND_W-1:0] Q_MAX = (RND_W'(1) <<< FRAC) - RND_W'(1);
  localparam logic signed [RND_W-1:0] Q_MIN = -(RND_W'(1) <<< FRAC);

  logic signed [SAMPLE_BITS-1:0] a [2];
  logic signed [SAMPLE_BITS-1:0] b [2];
  logic signed [PROD_W-1:0]      prod [2];
  logic                          prod_valid;
  logic signed [ACC_W-1:0]       acc [2];
  logic signed [RND_W-1:0]       rnd [2];
  logic signed [RND_W-1:0]       q [2];
  logic signed [SAMPLE_BITS-1:0] res [2];

  assign a[0] = hist_one;
  assign a[1] = hist_two;
  assign b[0] = coef_one;
  assign b[1] = coef_two;

  always_ff @(posedge clk) begin
    prod_valid <= ctrl.step;
    for (int l = 0; l < 2; l++) begin
      prod[l] <= ctrl.en[l] ? PROD_W'(a[l] * b[l]) : PROD_W'(0);
      if (ctrl.clear) begin
        acc[l] <= '0;
      end else if (prod_valid) begin
        acc[l] <= acc[l] + ACC_W'(prod[l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rnd[l] = RND_W'(acc[l]) + HALF;
      q[l]   = rnd[l] >>> FRAC;
      if (q[l] > Q_MAX) begin
        res[l] = SAMPLE_BITS'(Q_MAX);
      end else if (q[l] < Q_MIN) begin
        res[l] = SAMPLE_BITS'(Q_MIN);
      end else begin
        res[l] = SAMPLE_BITS'(q[l]);
      end
    end
  end

  assign res_one = res[0];
  assign res_two = res[1];

endmodule

// ===== rtl/dual_channel_selectable_fir.sv =====
`timescale 1ns / 1ps
// Top level of the dual-channel selectable FIR: histories, coefficient
// tables, sequencer and output register. Depends on dcsf_pkg and dcsf_mac.
//
// After reset the block zeroes its four memories, one address a cycle,
// with in_ready low; configuration writes are taken throughout. A sample
// transaction steps through N taps, then drains the MAC pipeline and
// finishes; when N is zero it goes straight to finishing. N is the larger
// of the two channels' tap counts (zero for a bypassed channel, counts above
// MAX_TAPS held at MAX_TAPS): the two-lane MAC does one tap per channel per
// cycle, fed by one read port on each history and coefficient memory. The
// result waits in an output register, so the next transaction is taken
// meanwhile; a further result stalls only if that register is still full.
module dual_channel_selectable_fir
  import dcsf_pkg::*;
#(
  parameter int MAX_TAPS    = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int IDX_W = $clog2(MAX_TAPS),
  localparam int TAP_W = $clog2(MAX_TAPS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic signed [SAMPLE_BITS-1:0] sample_one,
  input  logic signed [SAMPLE_BITS-1:0] sample_two,
  input  logic [IDX_W-1:0]              coef_index,
  input  logic signed [SAMPLE_BITS-1:0] coef_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_one,
  output logic signed [SAMPLE_BITS-1:0] out_two,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [TAP_W-1:0]              cfg_data
);

  localparam logic [TAP_W-1:0] TAPS_MAX = TAP_W'(MAX_TAPS);
  localparam logic [IDX_W-1:0] ADDR_TOP = IDX_W'(MAX_TAPS - 1);

  state_t state, state_next;

  logic [1:0]       mode_one, mode_two;
  logic [TAP_W-1:0] hp_taps, lp_taps;
  logic [TAP_W-1:0] hp_sat, lp_sat, n1_new, n2_new, nit_new;
  logic [TAP_W-1:0] n1, n2, niter, tap;
  logic [IDX_W-1:0] wp, hptr, clr_addr;
  logic [1:0]       dcnt;
  logic signed [SAMPLE_BITS-1:0] samp_one, samp_two;

  logic signed [SAMPLE_BITS-1:0] hist_mem_one [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem_two [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hp_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] lp_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] h1_rd, h2_rd, hp_rd, lp_rd;
  logic                          rd_step;
  logic [1:0]                    rd_en;

  logic in_acc, samp_acc, hp_load, lp_load, idx_ok, last_tap, fin_go;
  logic signed [SAMPLE_BITS-1:0] res_one, res_two;
  mac_ctrl_t mac_ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign samp_acc  = in_acc && (mode == KIND_SAMPLE);
  assign idx_ok    = TAP_W'(coef_index) < TAPS_MAX;
  assign hp_load   = in_acc && (mode == KIND_LOAD_HP) && idx_ok;
  assign lp_load   = in_acc && (mode == KIND_LOAD_LP) && idx_ok;
  assign last_tap  = (tap == niter - TAP_W'(1));
  assign fin_go    = !out_valid || out_ready;

  assign hp_sat  = (hp_taps > TAPS_MAX) ? TAPS_MAX : hp_taps;
  assign lp_sat  = (lp_taps > TAPS_MAX) ? TAPS_MAX : lp_taps;
  assign n1_new  = (mode_one == FILT_HIGH) ? hp_sat : (mode_one == FILT_LOW) ? lp_sat : '0;
  assign n2_new  = (mode_two == FILT_HIGH) ? hp_sat : (mode_two == FILT_LOW) ? lp_sat : '0;
  assign nit_new = (n1_new > n2_new) ? n1_new : n2_new;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_one <= '0;
      mode_two <= '0;
      hp_taps  <= TAP_W'(1);
      lp_taps  <= TAP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE_ONE: mode_one <= cfg_data[1:0];
        REG_MODE_TWO: mode_two <= cfg_data[1:0];
        REG_HP_TAPS:  hp_taps  <= cfg_data;
        REG_LP_TAPS:  lp_taps  <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories: zeroed during the clearing sweep
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      hist_mem_one[clr_addr] <= '0;
      hist_mem_two[clr_addr] <= '0;
      hp_mem[clr_addr]       <= '0;
      lp_mem[clr_addr]       <= '0;
    end else begin
      if (samp_acc) begin
        hist_mem_one[wp] <= sample_one;
        hist_mem_two[wp] <= sample_two;
      end
      if (hp_load) begin
        hp_mem[coef_index] <= coef_value;
      end
      if (lp_load) begin
        lp_mem[coef_index] <= coef_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    h1_rd <= hist_mem_one[hptr];
    h2_rd <= hist_mem_two[hptr];
    hp_rd <= hp_mem[tap[IDX_W-1:0]];
    lp_rd <= lp_mem[tap[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_step <= 1'b0;
      rd_en   <= '0;
    end else begin
      rd_step <= (state == S_RUN);
      rd_en   <= {(state == S_RUN) && (tap < n2), (state == S_RUN) && (tap < n1)};
    end
  end

  assign mac_ctrl.clear = samp_acc;
  assign mac_ctrl.step  = rd_step;
  assign mac_ctrl.en    = rd_en;

  dcsf_mac #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .hist_one (h1_rd),
    .hist_two (h2_rd),
    .coef_one ((mode_one == FILT_HIGH) ? hp_rd : lp_rd),
    .coef_two ((mode_two == FILT_HIGH) ? hp_rd : lp_rd),
    .res_one  (res_one),
    .res_two  (res_two)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_TOP) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (samp_acc) state_next = (nit_new == '0) ? S_FINISH : S_RUN;
      end
      S_RUN: begin
        if (last_tap) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (dcnt == 2'd1) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (fin_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      wp       <= '0;
    end else begin
      if (state == S_CLEAR) clr_addr <= clr_addr + IDX_W'(1);
      if (samp_acc) wp <= (wp == ADDR_TOP) ? '0 : wp + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (samp_acc) begin
      hptr     <= wp;
      tap      <= '0;
      n1       <= n1_new;
      n2       <= n2_new;
      niter    <= nit_new;
      samp_one <= sample_one;
      samp_two <= sample_two;
    end else if (state == S_RUN) begin
      hptr <= (hptr == '0) ? ADDR_TOP : hptr - IDX_W'(1);
      tap  <= tap + TAP_W'(1);
    end
    dcnt <= (state == S_DRAIN) ? dcnt + 2'd1 : 2'd0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && fin_go) begin
      out_one <= (n1 == '0 && mode_one != FILT_HIGH && mode_one != FILT_LOW) ? samp_one : res_one;
      out_two <= (n2 == '0 && mode_two != FILT_HIGH && mode_two != FILT_LOW) ? samp_two : res_two;
    end
  end

endmodule
